@@ src/triangle_tangent_bitangent_defines.svh @@
// Assertion macros for the tangent/bitangent block.
`ifndef TRIANGLE_TANGENT_BITANGENT_DEFINES_SVH
`define TRIANGLE_TANGENT_BITANGENT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TTB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TTB_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTB_ASSERT(label, clk, rst, prop, msg)
`define TTB_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

@@ src/ttb_pkg.sv @@
package ttb_pkg;
  localparam int PosWidth = 24;
  localparam int UvWidth = 16;
  localparam int DeltaPosWidth = PosWidth + 1;
  localparam int DeltaUvWidth = UvWidth + 1;
  localparam int NumWidth = DeltaPosWidth + DeltaUvWidth + 1;
  localparam int DetWidth = 2 * DeltaUvWidth + 1;
  // quotient holds 18 integer bits plus 16 fraction bits before saturation
  localparam int QuotWidth = 34;
  localparam int NumComp = 6;

  typedef struct packed {
    logic signed [PosWidth-1:0] pos_x;
    logic signed [PosWidth-1:0] pos_y;
    logic signed [PosWidth-1:0] pos_z;
    logic signed [UvWidth-1:0] tex_u;
    logic signed [UvWidth-1:0] tex_v;
    logic last_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic signed [31:0] bitangent_x;
    logic signed [31:0] bitangent_y;
    logic signed [31:0] bitangent_z;
    logic degenerate;
    logic last_of_triangle;
  } result_t;

  typedef struct packed {
    logic signed [DeltaPosWidth-1:0] e1_x, e1_y, e1_z;
    logic signed [DeltaPosWidth-1:0] e2_x, e2_y, e2_z;
    logic signed [DeltaUvWidth-1:0] du1, dv1, du2, dv2;
  } tri_t;
endpackage

@@ src/ttb_front.sv @@
// Gather corners; emit one triangle of deltas on every third corner.
module ttb_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ttb_pkg::vertex_t in_data,
  output logic            tri_valid,
  input  logic            tri_ready,
  output ttb_pkg::tri_t   tri_data
);
  import ttb_pkg::*;

  logic [1:0] corner_count;
  vertex_t c0, c1;
  logic take;

  assign in_ready = !tri_valid || tri_ready;
  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_count <= '0;
      tri_valid <= 1'b0;
      c0 <= '0;
      c1 <= '0;
    end else begin
      if (take && corner_count == 2'd2) tri_valid <= 1'b1;
      else if (tri_ready) tri_valid <= 1'b0;
      if (take) begin
        if (corner_count == 2'd2) begin
          tri_data.e1_x <= DeltaPosWidth'(c1.pos_x) - DeltaPosWidth'(c0.pos_x);
          tri_data.e1_y <= DeltaPosWidth'(c1.pos_y) - DeltaPosWidth'(c0.pos_y);
          tri_data.e1_z <= DeltaPosWidth'(c1.pos_z) - DeltaPosWidth'(c0.pos_z);
          tri_data.e2_x <= DeltaPosWidth'(in_data.pos_x) - DeltaPosWidth'(c0.pos_x);
          tri_data.e2_y <= DeltaPosWidth'(in_data.pos_y) - DeltaPosWidth'(c0.pos_y);
          tri_data.e2_z <= DeltaPosWidth'(in_data.pos_z) - DeltaPosWidth'(c0.pos_z);
          tri_data.du1 <= DeltaUvWidth'(c1.tex_u) - DeltaUvWidth'(c0.tex_u);
          tri_data.dv1 <= DeltaUvWidth'(c1.tex_v) - DeltaUvWidth'(c0.tex_v);
          tri_data.du2 <= DeltaUvWidth'(in_data.tex_u) - DeltaUvWidth'(c0.tex_u);
          tri_data.dv2 <= DeltaUvWidth'(in_data.tex_v) - DeltaUvWidth'(c0.tex_v);
          corner_count <= '0;
        end else begin
          if (corner_count == 2'd0) c0 <= in_data;
          else c1 <= in_data;
          corner_count <= in_data.last_vertex ? 2'd0 : corner_count + 2'd1;
        end
      end
    end
  end
endmodule

@@ src/ttb_back.sv @@
// Products, sums, a restoring divider shared by six components, then three results.
module ttb_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            tri_valid,
  output logic            tri_ready,
  input  ttb_pkg::tri_t   tri_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ttb_pkg::result_t out_data
);
  import ttb_pkg::*;
  `include "triangle_tangent_bitangent_defines.svh"

  typedef enum logic [2:0] {S_IDLE, S_PROD, S_SUM, S_DIV, S_EMIT} state_t;
  localparam int DivSteps = QuotWidth + NumWidth;
  localparam int StepWidth = $clog2(DivSteps + 1);

  state_t state;
  tri_t t;
  logic signed [NumWidth-1:0] pa [NumComp];
  logic signed [NumWidth-1:0] pb [NumComp];
  logic signed [NumWidth-1:0] num [NumComp];
  logic signed [DetWidth-1:0] da, db, det;
  logic signed [31:0] res [NumComp];
  logic [2:0] comp;
  logic [StepWidth-1:0] step;
  logic [NumWidth+16-1:0] dividend;
  logic [DetWidth:0] rem;
  logic [QuotWidth-1:0] quot;
  logic qover;
  logic [DetWidth-1:0] dmag;
  logic neg;
  logic [1:0] emit_cnt;
  logic [DetWidth:0] rem_shift;
  logic [QuotWidth-1:0] qsat;
  logic [NumWidth-1:0] nmag;

  assign tri_ready = (state == S_IDLE);
  assign rem_shift = {rem[DetWidth-1:0], dividend[NumWidth+16-1]};
  assign nmag = num[comp][NumWidth-1] ? NumWidth'(-num[comp]) : num[comp];

  // a quotient bit lost off the top means the result is far out of range
  always_comb begin
    qsat = quot;
    if (neg) begin
      if (qover || quot > QuotWidth'(64'h8000_0000)) qsat = QuotWidth'(64'h8000_0000);
    end else if (qover || quot > QuotWidth'(64'h7FFF_FFFF)) qsat = QuotWidth'(64'h7FFF_FFFF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (tri_valid) begin
          t <= tri_data;
          state <= S_PROD;
        end
        S_PROD: begin
          pa[0] <= NumWidth'(t.e1_x * t.dv2); pb[0] <= NumWidth'(t.e2_x * t.dv1);
          pa[1] <= NumWidth'(t.e1_y * t.dv2); pb[1] <= NumWidth'(t.e2_y * t.dv1);
          pa[2] <= NumWidth'(t.e1_z * t.dv2); pb[2] <= NumWidth'(t.e2_z * t.dv1);
          pa[3] <= NumWidth'(t.e2_x * t.du1); pb[3] <= NumWidth'(t.e1_x * t.du2);
          pa[4] <= NumWidth'(t.e2_y * t.du1); pb[4] <= NumWidth'(t.e1_y * t.du2);
          pa[5] <= NumWidth'(t.e2_z * t.du1); pb[5] <= NumWidth'(t.e1_z * t.du2);
          da <= DetWidth'(t.du1 * t.dv2);
          db <= DetWidth'(t.dv1 * t.du2);
          state <= S_SUM;
        end
        S_SUM: begin
          for (int i = 0; i < NumComp; i++) num[i] <= pa[i] - pb[i];
          det <= da - db;
          comp <= '0;
          step <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (det == '0) begin
            for (int i = 0; i < NumComp; i++) res[i] <= '0;
            emit_cnt <= '0;
            state <= S_EMIT;
          end else if (step == '0) begin
            // load one component: magnitude scaled by 2^16
            dividend <= {nmag, 16'd0};
            rem <= '0;
            quot <= '0;
            qover <= 1'b0;
            dmag <= det[DetWidth-1] ? DetWidth'(-det) : det;
            neg <= num[comp][NumWidth-1] ^ det[DetWidth-1];
            step <= StepWidth'(1);
          end else if (step <= StepWidth'(NumWidth + 16)) begin
            dividend <= dividend << 1;
            qover <= qover | quot[QuotWidth-1];
            if (rem_shift >= {1'b0, dmag}) begin
              rem <= rem_shift - {1'b0, dmag};
              quot <= {quot[QuotWidth-2:0], 1'b1};
            end else begin
              rem <= rem_shift;
              quot <= {quot[QuotWidth-2:0], 1'b0};
            end
            step <= step + StepWidth'(1);
          end else begin
            res[comp] <= neg ? 32'(-qsat) : 32'(qsat);
            step <= '0;
            if (comp == 3'(NumComp - 1)) begin
              emit_cnt <= '0;
              state <= S_EMIT;
            end else comp <= comp + 3'd1;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data.tangent_x <= res[0];
            out_data.tangent_y <= res[1];
            out_data.tangent_z <= res[2];
            out_data.bitangent_x <= res[3];
            out_data.bitangent_y <= res[4];
            out_data.bitangent_z <= res[5];
            out_data.degenerate <= (det == '0);
            out_data.last_of_triangle <= (emit_cnt == 2'd2);
            emit_cnt <= emit_cnt + 2'd1;
            if (emit_cnt == 2'd2) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && out_ready && !(state == S_EMIT)) out_valid <= 1'b0;
    end
  end

  `TTB_ASSERT(a_idle_ready, clk, rst, tri_ready |-> (state == S_IDLE), "ready outside idle")
  `TTB_ASSERT(a_deg_zero, clk, rst, (out_valid && out_data.degenerate) |-> (out_data.tangent_x == 0 && out_data.bitangent_z == 0), "degenerate not zero")
  `TTB_ASSERT_RST(a_rst, clk, $past(rst) |-> !out_valid, "valid after reset")
endmodule

@@ src/triangle_tangent_bitangent.sv @@
// Per-triangle tangent and bitangent from UVs. Vertices transfer one per cycle into
// the front end unless a finished triangle waits on a busy back end; the third
// corner of each triangle forms edge and UV deltas, which wait in a one-entry
// register for the back end. The back end forms products, then sums, then a shared
// restoring divider handles six components in turn, and three results follow, the
// last marked. Meanwhile the front end takes all three corners of the next triangle
// and holds its deltas until the back end is free.
// A zero determinant skips the divider and yields zero vectors with degenerate set.
// A mesh end on a partial triangle drops it.
module triangle_tangent_bitangent (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ttb_pkg::vertex_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ttb_pkg::result_t out_data
);
  import ttb_pkg::*;

  logic  tri_valid, tri_ready;
  tri_t  tri_data;

  // front: hold corners, form deltas
  ttb_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .tri_valid, .tri_ready, .tri_data
  );

  // back: products, divide, emit three transfers
  ttb_back u_back (
    .clk, .rst, .tri_valid, .tri_ready, .tri_data,
    .out_valid, .out_ready, .out_data
  );
endmodule
